### src/rmr_pkg.sv
// ----------------------------------------------------------------------------
// rmr_pkg: shared types and constants of the rational multiply-add unit
// Holds the request and result transfer structs and the default width.
// ----------------------------------------------------------------------------
package rmr_pkg;

    // Width of every numeric field on the ports.
    localparam int FIELD_W = 64;

    // Default arithmetic width inside the unit.
    localparam int DATA_WIDTH_DEF = 64;

    // Action codes.
    localparam logic ACT_MULADD = 1'b0;
    localparam logic ACT_MUL    = 1'b1;

    // One request item.
    typedef struct packed {
        logic                      action;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
        logic signed [FIELD_W-1:0] factor;
    } req_t;

    // One result item.
    typedef struct packed {
        logic signed [FIELD_W-1:0] res_num;
        logic signed [FIELD_W-1:0] res_den;
    } res_t;

endpackage

### src/rational_muladd_reduce.sv
// ----------------------------------------------------------------------------
// rational_muladd_reduce: exact rational multiply-add with gcd reduction
// A plain product runs one bit-serial product fewer than a multiply-add, and
// the divisions are skipped when no reduction is done. A new item is taken
// only in idle, after the previous item is finished. The shared adder is
// stepped one bit per cycle through the products and the divisions.
// Reset clears the sequencer and the result strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rational_muladd_reduce #(
    parameter int DATA_WIDTH = rmr_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rmr_pkg::req_t req,
    output logic          done,
    output rmr_pkg::res_t res
);

    localparam int W = DATA_WIDTH;

    logic [W-1:0] an, ad, bn, bd, fx;
    logic [W-1:0] ad_c, bd_c;
    logic         seq_busy, seq_done;
    logic [W-1:0] seq_num, seq_den;

    logic          done_reg;
    rmr_pkg::res_t res_reg;

    // Operands are the low W bits of each field.
    assign an = req.a_num[W-1:0];
    assign ad = req.a_den[W-1:0];
    assign bn = req.b_num[W-1:0];
    assign bd = req.b_den[W-1:0];
    assign fx = req.factor[W-1:0];

    // A zero numerator or denominator turns the denominator into one.
    assign ad_c = (an == '0 || ad == '0) ? W'(1) : ad;
    assign bd_c = (bn == '0 || bd == '0) ? W'(1) : bd;

    rmr_seq #(.W(W)) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .act   (req.action),
        .an    (an),
        .ad    (ad_c),
        .bn    (bn),
        .bd    (bd_c),
        .fx    (fx),
        .busy  (seq_busy),
        .done  (seq_done),
        .num   (seq_num),
        .den   (seq_den)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= seq_done;
    end

    // Result register: sign-extend and force the denominator to one on zero.
    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            res_reg.res_num <= rmr_pkg::FIELD_W'(signed'(seq_num));
            if (seq_num == '0)
                res_reg.res_den <= rmr_pkg::FIELD_W'(1);
            else
                res_reg.res_den <= rmr_pkg::FIELD_W'(signed'(seq_den));
        end
    end

    assign busy = seq_busy;
    assign done = done_reg;
    assign res  = res_reg;

endmodule

### src/rmr_addsub.sv
// ----------------------------------------------------------------------------
// rmr_addsub: shared adder / subtractor
// The only wide arithmetic unit of the block. With sub set it returns a - b
// and a carry that is high when a >= b as unsigned values.
// ----------------------------------------------------------------------------
module rmr_addsub #(
    parameter int W = rmr_pkg::DATA_WIDTH_DEF
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] sum,
    output logic         cout
);

    logic [W:0] total;

    // Two's complement subtract folds into the carry in.
    assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
    assign sum   = total[W-1:0];
    assign cout  = total[W];

endmodule

### src/rmr_seq.sv
// ----------------------------------------------------------------------------
// rmr_seq: sequencer and datapath registers
// Runs the bit-serial products, the sum, the magnitudes, a binary gcd,
// the two restoring divisions and the sign restore, all through one shared adder.
// ----------------------------------------------------------------------------
module rmr_seq #(
    parameter int W = rmr_pkg::DATA_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         act,
    input  logic [W-1:0] an,
    input  logic [W-1:0] ad,
    input  logic [W-1:0] bn,
    input  logic [W-1:0] bd,
    input  logic [W-1:0] fx,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] num,
    output logic [W-1:0] den
);

    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MLOAD = 12'b0000_0000_0010,
        S_MUL   = 12'b0000_0000_0100,
        S_SUM   = 12'b0000_0000_1000,
        S_MAGN  = 12'b0000_0001_0000,
        S_MAGD  = 12'b0000_0010_0000,
        S_GCD   = 12'b0000_0100_0000,
        S_GFIN  = 12'b0000_1000_0000,
        S_DLOAD = 12'b0001_0000_0000,
        S_DIV   = 12'b0010_0000_0000,
        S_SGN   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Control registers.
    logic [1:0]    job_reg;
    logic [CW-1:0] cnt_reg;
    logic          dj_reg;

    // Payload registers.
    logic          act_reg;
    logic [W-1:0]  an_reg, ad_reg, bn_reg, bd_reg, fx_reg;
    logic [W-1:0]  t1_reg, t2_reg, num_reg, den_reg;
    logic [W-1:0]  mc_reg, ml_reg, acc_reg;
    logic [W-1:0]  gp_reg, gq_reg, g_reg, rem_reg, dq_reg;
    logic [CW-1:0] gk_reg;
    logic          nneg_reg, dneg_reg, red_reg;

    // Shared adder connections.
    logic [W-1:0] alu_a, alu_b, alu_sum;
    logic         alu_sub, alu_cout;

    logic [W-1:0] acc_fin;
    logic [W-1:0] g_val;
    logic [W-1:0] rem_shift;

    rmr_addsub #(.W(W)) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum),
        .cout (alu_cout)
    );

    assign acc_fin   = ml_reg[0] ? alu_sum : acc_reg;
    assign g_val     = (gp_reg | gq_reg) << gk_reg;
    assign rem_shift = {rem_reg[W-2:0], dq_reg[W-1]};

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_MUL:
            begin
                alu_a = acc_reg;
                alu_b = mc_reg;
            end
            S_SUM:
            begin
                alu_a = t2_reg;
                alu_b = t1_reg;
            end
            S_MAGN:
            begin
                alu_b   = num_reg;
                alu_sub = 1'b1;
            end
            S_MAGD:
            begin
                alu_b   = den_reg;
                alu_sub = 1'b1;
            end
            S_GCD:
            begin
                alu_a   = gp_reg;
                alu_b   = gq_reg;
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = rem_shift;
                alu_b   = g_reg;
                alu_sub = 1'b1;
            end
            S_SGN:
            begin
                alu_b   = dq_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_MLOAD;
            S_MLOAD: state_next = S_MUL;
            S_MUL:
            begin
                if (cnt_reg == LAST)
                    state_next = (job_reg == 2'd3) ? S_SUM : S_MLOAD;
            end
            S_SUM:   state_next = S_MAGN;
            S_MAGN:  state_next = S_MAGD;
            S_MAGD:
            begin
                if (num_reg == '0 || den_reg == '0)
                    state_next = S_DLOAD;
                else
                    state_next = S_GCD;
            end
            S_GCD:
            begin
                if (gp_reg == '0 || gq_reg == '0)
                    state_next = S_GFIN;
            end
            S_GFIN:  state_next = S_DLOAD;
            S_DLOAD: state_next = red_reg ? S_DIV : S_SGN;
            S_DIV:   if (cnt_reg == LAST) state_next = S_SGN;
            S_SGN:   state_next = dj_reg ? S_DONE : S_DLOAD;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= '0;
            cnt_reg   <= '0;
            dj_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    job_reg <= '0;
                    dj_reg  <= 1'b0;
                end
                S_MLOAD: cnt_reg <= '0;
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST)
                    begin
                        // The product chain for a plain product skips job two.
                        if (job_reg == 2'd1 && act_reg == rmr_pkg::ACT_MUL)
                            job_reg <= 2'd3;
                        else
                            job_reg <= job_reg + 1'b1;
                    end
                end
                S_DLOAD: cnt_reg <= '0;
                S_DIV:   cnt_reg <= cnt_reg + 1'b1;
                S_SGN:   dj_reg  <= 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_reg <= act;
                    an_reg  <= an;
                    ad_reg  <= ad;
                    bn_reg  <= bn;
                    bd_reg  <= bd;
                    fx_reg  <= fx;
                end
            end
            S_MLOAD:
            begin
                acc_reg <= '0;
                case (job_reg)
                    2'd0:
                    begin
                        mc_reg <= an_reg;
                        ml_reg <= (act_reg == rmr_pkg::ACT_MUL) ? bn_reg : bd_reg;
                    end
                    2'd1:
                    begin
                        mc_reg <= (act_reg == rmr_pkg::ACT_MUL) ? t1_reg : bn_reg;
                        ml_reg <= (act_reg == rmr_pkg::ACT_MUL) ? fx_reg : ad_reg;
                    end
                    2'd2:
                    begin
                        mc_reg <= t2_reg;
                        ml_reg <= fx_reg;
                    end
                    default:
                    begin
                        mc_reg <= ad_reg;
                        ml_reg <= bd_reg;
                    end
                endcase
            end
            S_MUL:
            begin
                // One multiplier bit per cycle, product wraps at W bits.
                acc_reg <= acc_fin;
                mc_reg  <= {mc_reg[W-2:0], 1'b0};
                ml_reg  <= {1'b0, ml_reg[W-1:1]};
                if (cnt_reg == LAST)
                begin
                    case (job_reg)
                        2'd0:    t1_reg  <= acc_fin;
                        2'd3:    den_reg <= acc_fin;
                        default: t2_reg  <= acc_fin;
                    endcase
                end
            end
            S_SUM:
            begin
                num_reg <= (act_reg == rmr_pkg::ACT_MUL) ? t2_reg : alu_sum;
            end
            S_MAGN:
            begin
                nneg_reg <= num_reg[W-1];
                if (num_reg[W-1])
                    num_reg <= alu_sum;
            end
            S_MAGD:
            begin
                dneg_reg <= den_reg[W-1];
                if (den_reg[W-1])
                    den_reg <= alu_sum;
                gp_reg  <= num_reg;
                gq_reg  <= den_reg[W-1] ? alu_sum : den_reg;
                gk_reg  <= '0;
                red_reg <= 1'b0;
            end
            S_GCD:
            begin
                // Binary gcd: strip common twos, then subtract odd from odd.
                if (gp_reg == '0 || gq_reg == '0)
                begin
                    gp_reg <= gp_reg;
                end
                else if (!gp_reg[0] && !gq_reg[0])
                begin
                    gp_reg <= {1'b0, gp_reg[W-1:1]};
                    gq_reg <= {1'b0, gq_reg[W-1:1]};
                    gk_reg <= gk_reg + 1'b1;
                end
                else if (!gp_reg[0])
                begin
                    gp_reg <= {1'b0, gp_reg[W-1:1]};
                end
                else if (!gq_reg[0])
                begin
                    gq_reg <= {1'b0, gq_reg[W-1:1]};
                end
                else if (alu_cout)
                begin
                    gp_reg <= {1'b0, alu_sum[W-1:1]};
                end
                else
                begin
                    gp_reg <= gq_reg;
                    gq_reg <= gp_reg;
                end
            end
            S_GFIN:
            begin
                g_reg   <= g_val;
                red_reg <= (g_val[W-1:1] != '0);
            end
            S_DLOAD:
            begin
                rem_reg <= '0;
                dq_reg  <= dj_reg ? den_reg : num_reg;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                rem_reg <= alu_cout ? alu_sum : rem_shift;
                dq_reg  <= {dq_reg[W-2:0], alu_cout};
            end
            S_SGN:
            begin
                if (dj_reg)
                    den_reg <= dneg_reg ? alu_sum : dq_reg;
                else
                    num_reg <= nneg_reg ? alu_sum : dq_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign num  = num_reg;
    assign den  = den_reg;

endmodule

### tb/rational_muladd_reduce_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_muladd_reduce_tb: self-checking bench of the rational multiply-add
// Drives fraction pairs through the start/busy command port. It predicts each
// reduced result locally and compares every done strobe against the oldest
// prediction. It covers directed corner cases, a full drain pause and a long
// random stream with random and zero gaps.
// ----------------------------------------------------------------------------
module rational_muladd_reduce_tb;

    import rmr_pkg::*;

    localparam longint FIELD_MIN = 64'sh8000_0000_0000_0000;
    localparam longint FIELD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    res_t  res;

    // Predicted results still waiting for their done strobe, oldest first.
    res_t  pending_fractions[$];
    int    mismatch_count = 0;
    int    result_count   = 0;

    rational_muladd_reduce dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    // Free-running 10 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: ends a hung run well past the slowest legal completion.
    initial
    begin
        #(64'd50_000_000);
        $display("rational_muladd_reduce_tb NOT OK");
        $finish;
    end

    // Cross-multiplies the two fractions and reduces by Euclid's gcd.
    // All arithmetic wraps at 64 bits; a zero numerator forces a unit denominator.
    function automatic res_t reduce_fraction(input req_t r);
        bit [63:0] an, ad, bn, bd, fx;
        bit [63:0] num, den, mag_num, mag_den, p, q, t, g;
        bit        num_neg, den_neg;
        res_t      out;
        an = r.a_num;
        ad = r.a_den;
        bn = r.b_num;
        bd = r.b_den;
        fx = r.factor;
        if (an == 0 || ad == 0)
            ad = 64'd1;
        if (bn == 0 || bd == 0)
            bd = 64'd1;
        if (r.action == ACT_MULADD)
            num = an * bd + bn * ad * fx;
        else
            num = an * bn * fx;
        den = ad * bd;
        num_neg = num[63];
        den_neg = den[63];
        mag_num = num_neg ? 64'd0 - num : num;
        mag_den = den_neg ? 64'd0 - den : den;
        // The gcd of anything with zero is taken as zero: no reduction then.
        if (mag_num == 0 || mag_den == 0)
        begin
            g = 64'd0;
        end
        else
        begin
            p = (mag_num > mag_den) ? mag_num : mag_den;
            q = (mag_num > mag_den) ? mag_den : mag_num;
            while (q != 0)
            begin
                t = p % q;
                p = q;
                q = t;
            end
            g = p;
        end
        if (g > 64'd1)
        begin
            num = num_neg ? 64'd0 - (mag_num / g) : mag_num / g;
            den = den_neg ? 64'd0 - (mag_den / g) : mag_den / g;
        end
        if (num == 0)
            den = 64'd1;
        out.res_num = num;
        out.res_den = den;
        return out;
    endfunction

    function automatic req_t make_req(input logic act, input longint an, input longint ad,
                                      input longint bn, input longint bd, input longint fx);
        req_t r;
        r.action = act;
        r.a_num  = an;
        r.a_den  = ad;
        r.b_num  = bn;
        r.b_den  = bd;
        r.factor = fx;
        return r;
    endfunction

    // Field values weighted toward zero, unit, extremes and small composites,
    // so that reductions happen often while full-width patterns still appear.
    function automatic longint rand_field();
        longint v;
        case ($urandom_range(0, 11))
            0: v = 0;
            1: v = $urandom_range(0, 1) ? 64'sd1 : -64'sd1;
            2: v = $urandom_range(0, 1) ? FIELD_MIN : FIELD_MAX;
            3, 4, 5: v = longint'(int'($urandom_range(0, 2000)) - 1000);
            6, 7:
            begin
                v = longint'($urandom_range(1, 60)) * longint'($urandom_range(1, 60));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            8: v = 64'sd1 <<< $urandom_range(0, 63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic req_t rand_req();
        return make_req(logic'($urandom_range(0, 1)), rand_field(), rand_field(),
                        rand_field(), rand_field(), rand_field());
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("result %0d: %s got %h expected %h", result_count, what, got, want);
        mismatch_count++;
    endtask

    // Sends one request after an idle gap. Start stays high across a zero gap,
    // so it is never dropped and raised in the same time step.
    task automatic send_request(input req_t r, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        pending_fractions.push_back(reduce_fraction(r));
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_fractions.size() != 0)
            @(posedge clk);
    endtask

    // Every done strobe is one result transfer; compare it with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (pending_fractions.size() == 0)
            begin
                report_mismatch("unexpected transfer, res_num", res.res_num, '0);
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (res.res_num !== want.res_num)
                    report_mismatch("res_num", res.res_num, want.res_num);
                if (res.res_den !== want.res_den)
                    report_mismatch("res_den", res.res_den, want.res_den);
            end
        end
    end

    // Corner cases: operand cleanup, signs, wraparound and the gcd edge values.
    task automatic test_directed_cases();
        req_t list[$];
        list.push_back(make_req(ACT_MULADD, 1, 2, 1, 3, 1));
        list.push_back(make_req(ACT_MUL, 2, 4, 3, 6, 4));
        // A zero numerator or denominator makes that operand's denominator one.
        list.push_back(make_req(ACT_MULADD, 0, 5, 3, 7, 2));
        list.push_back(make_req(ACT_MULADD, 5, 0, 3, 7, 2));
        list.push_back(make_req(ACT_MULADD, 4, 9, 0, 7, 3));
        list.push_back(make_req(ACT_MUL, 4, 9, 6, 0, 3));
        list.push_back(make_req(ACT_MUL, 0, 0, 0, 0, 0));
        // Negative denominators are kept as they are.
        list.push_back(make_req(ACT_MULADD, 1, -2, 1, 3, 1));
        list.push_back(make_req(ACT_MUL, -6, -4, 10, -15, -1));
        // Sum that cancels to zero forces a unit denominator.
        list.push_back(make_req(ACT_MULADD, 1, 2, -1, 2, 1));
        list.push_back(make_req(ACT_MULADD, 7, 3, 5, 11, 0));
        list.push_back(make_req(ACT_MUL, 7, 3, 5, 11, 0));
        // Most negative and most positive values.
        list.push_back(make_req(ACT_MUL, FIELD_MIN, 1, 1, 1, 1));
        list.push_back(make_req(ACT_MUL, FIELD_MIN, FIELD_MIN, 1, 1, 1));
        list.push_back(make_req(ACT_MULADD, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                                FIELD_MAX));
        list.push_back(make_req(ACT_MULADD, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MIN,
                                FIELD_MIN));
        list.push_back(make_req(ACT_MUL, -1, -1, -1, -1, -1));
        // Denominator product wraps to zero: no reduction.
        list.push_back(make_req(ACT_MULADD, 3, 64'sh1_0000_0000, 5, 64'sh1_0000_0000, 2));
        // Numerator product wraps to zero.
        list.push_back(make_req(ACT_MUL, 64'sh1_0000_0000, 3, 64'sh1_0000_0000, 5, 1));
        // Large common factor.
        list.push_back(make_req(ACT_MULADD, 64'sd6_000_000_000_000, 64'sd4_000_000_000_000,
                                64'sd2_000_000_000_000, 64'sd8_000_000_000_000, 3));
        list.push_back(make_req(ACT_MULADD, 64'shAAAA_AAAA_AAAA_AAAA, 64'sh5555_5555_5555_5555,
                                64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA,
                                64'shAAAA_AAAA_AAAA_AAAA));
        list.push_back(make_req(ACT_MUL, 64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA,
                                64'shAAAA_AAAA_AAAA_AAAA, 64'sh5555_5555_5555_5555,
                                64'sh5555_5555_5555_5555));
        foreach (list[i])
            send_request(list[i], $urandom_range(0, 11));
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic test_drain_pause();
        repeat (6)
            send_request(rand_req(), 0);
        wait_results_drained();
        repeat (6)
            send_request(rand_req(), $urandom_range(0, 11));
    endtask

    // Long random stream; some stretches run with no idle cycles at all.
    task automatic test_random_stream(input int count);
        bit no_gaps;
        no_gaps = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_request(rand_req(), no_gaps ? 0 : $urandom_range(0, 11));
        end
    endtask

    initial
    begin
        start = 1'b0;
        req   = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_drain_pause();
        test_random_stream(920);

        wait_results_drained();
        repeat (800) @(posedge clk);
        if (mismatch_count == 0 && pending_fractions.size() == 0)
            $display("rational_muladd_reduce_tb OK");
        else
            $display("rational_muladd_reduce_tb NOT OK");
        $finish;
    end

endmodule

### rational_muladd_reduce.f
src/rmr_pkg.sv
src/rmr_addsub.sv
src/rmr_seq.sv
src/rational_muladd_reduce.sv
tb/rational_muladd_reduce_tb.sv
